// ===== src/aesd_pkg.sv =====
// shared types, constants and byte functions for the aes block decrypt
// no dependencies
package aesd_pkg;

  localparam int unsigned NR_MAX   = 14;
  localparam int unsigned RK_WORDS = 4 * (NR_MAX + 1);
  localparam int unsigned RK_IDX_W = $clog2(RK_WORDS);
  localparam int unsigned RND_W    = $clog2(NR_MAX + 1);

  typedef enum logic [1:0] {
    KEY_128 = 2'd0,
    KEY_192 = 2'd1,
    KEY_256 = 2'd2,
    KEY_SAT = 2'd3
  } key_len_e;

  typedef enum logic [2:0] {
    CFG_KEY_LENGTH = 3'd0,
    CFG_KEY_BITS_0 = 3'd1,
    CFG_KEY_BITS_1 = 3'd2,
    CFG_KEY_BITS_2 = 3'd3,
    CFG_KEY_BITS_3 = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic [63:0] cipher_hi;
    logic [63:0] cipher_lo;
  } in_data_t;

  typedef struct packed {
    logic [63:0] plain_hi;
    logic [63:0] plain_lo;
  } out_data_t;

  typedef logic [7:0] sbox_t [256];

  // field arithmetic for the tables, the inverse mix and the round constant update
  function automatic logic [7:0] xtime(input logic [7:0] a);
    xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] p;
    logic [7:0] x;
    p = 8'h00;
    x = a;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) p = p ^ x;
      x = xtime(x);
    end
    gf_mul = p;
  endfunction

  // inverse as a^254 by square and multiply
  function automatic logic [7:0] gf_inv(input logic [7:0] a);
    logic [7:0] r;
    logic [7:0] p;
    logic [7:0] e;
    r = 8'h01;
    p = a;
    e = 8'hfe;
    for (int i = 0; i < 8; i++) begin
      if (e[i]) r = gf_mul(r, p);
      p = gf_mul(p, p);
    end
    gf_inv = r;
  endfunction

  function automatic logic [7:0] sbox_calc(input logic [7:0] x);
    logic [7:0] b;
    b = gf_inv(x);
    sbox_calc = b ^ {b[6:0], b[7]} ^ {b[5:0], b[7:6]} ^ {b[4:0], b[7:5]}
              ^ {b[3:0], b[7:4]} ^ 8'h63;
  endfunction

  function automatic sbox_t gen_sbox();
    sbox_t t;
    for (int x = 0; x < 256; x++) t[x] = sbox_calc(8'(x));
    gen_sbox = t;
  endfunction

  function automatic sbox_t gen_isbox();
    sbox_t t;
    for (int x = 0; x < 256; x++) t[sbox_calc(8'(x))] = 8'(x);
    gen_isbox = t;
  endfunction

  localparam sbox_t SBOX  = gen_sbox();
  localparam sbox_t ISBOX = gen_isbox();

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    sub_word = {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
  endfunction

  // inverse mix of one column, byte of row 0 in the top bits
  function automatic logic [31:0] inv_mix_col(input logic [31:0] c);
    logic [7:0] a [4];
    logic [7:0] x2 [4];
    logic [7:0] x4 [4];
    logic [7:0] x8 [4];
    logic [7:0] m9 [4];
    logic [7:0] mb [4];
    logic [7:0] md [4];
    logic [7:0] me [4];
    for (int r = 0; r < 4; r++) begin
      a[r]  = c[31-8*r -: 8];
      x2[r] = xtime(a[r]);
      x4[r] = xtime(x2[r]);
      x8[r] = xtime(x4[r]);
      m9[r] = x8[r] ^ a[r];
      mb[r] = x8[r] ^ x2[r] ^ a[r];
      md[r] = x8[r] ^ x4[r] ^ a[r];
      me[r] = x8[r] ^ x4[r] ^ x2[r];
    end
    inv_mix_col = {me[0] ^ mb[1] ^ md[2] ^ m9[3],
                   m9[0] ^ me[1] ^ mb[2] ^ md[3],
                   md[0] ^ m9[1] ^ me[2] ^ mb[3],
                   mb[0] ^ md[1] ^ m9[2] ^ me[3]};
  endfunction

endpackage

// ===== src/aes_block_decrypt.sv =====
// top level: aes inverse cipher, config registers, key add stage and round pipeline
// depends on aesd_pkg, aesd_key_expand, aesd_round
// one request per cycle sustained unless the result is held; the key add stage and the
// fourteen round stages are registered and always walked, short keys pass the early
// ones unchanged. after reset or a key length or key bits write the schedule is built
// one word per cycle, and no request is taken until it is done.
module aes_block_decrypt import aesd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  in_data_t    in_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output out_data_t   out_data_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i
);

  key_len_e                 key_len_q;
  logic [3:0][63:0]         key_bits_q;
  logic                     cfg_we;
  logic                     cfg_hit;
  logic                     sched_ready;
  logic [NR_MAX:0][127:0]   round_keys;
  logic [127:0]             first_key;
  logic [RND_W-1:0]         nr;
  logic                     advance;
  logic                     v0_q;
  logic [127:0]             s0_q;
  logic [NR_MAX:0]          vld;
  logic [NR_MAX:0][127:0]   st;

  // config port
  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  always_comb begin
    unique case (cfg_idx_e'(cfg_index_i))
      CFG_KEY_LENGTH, CFG_KEY_BITS_0, CFG_KEY_BITS_1,
      CFG_KEY_BITS_2, CFG_KEY_BITS_3: cfg_hit = 1'b1;
      default:                        cfg_hit = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_len_q  <= KEY_128;
      key_bits_q <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_KEY_LENGTH: key_len_q     <= key_len_e'(cfg_data_i[1:0]);
        CFG_KEY_BITS_0: key_bits_q[0] <= cfg_data_i;
        CFG_KEY_BITS_1: key_bits_q[1] <= cfg_data_i;
        CFG_KEY_BITS_2: key_bits_q[2] <= cfg_data_i;
        CFG_KEY_BITS_3: key_bits_q[3] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  aesd_key_expand u_key_expand (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .restart_i    (cfg_we && cfg_hit),
    .key_len_i    (key_len_q),
    .key_bits_i   (key_bits_q),
    .ready_o      (sched_ready),
    .round_keys_o (round_keys),
    .first_key_o  (first_key)
  );

  always_comb begin
    unique case (key_len_q)
      KEY_128: nr = RND_W'(10);
      KEY_192: nr = RND_W'(12);
      default: nr = RND_W'(14);
    endcase
  end

  // pipeline moves as a whole unless the result is held
  assign advance    = !(vld[NR_MAX] && out_stall_i);
  assign in_stall_o = !advance || !sched_ready;

  // first key add
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else if (advance) begin
      v0_q <= in_valid_i && sched_ready;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) s0_q <= {in_data_i.cipher_hi, in_data_i.cipher_lo} ^ first_key;
  end

  assign vld[0] = v0_q;
  assign st[0]  = s0_q;

  // stage s handles round key 14-s, stages before 15-nr pass through
  for (genvar s = 1; s <= NR_MAX; s++) begin : g_round
    aesd_round u_round (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .advance_i (advance),
      .valid_i   (vld[s-1]),
      .state_i   (st[s-1]),
      .key_i     (round_keys[NR_MAX-s]),
      .active_i  (RND_W'(s) > (RND_W'(NR_MAX) - nr)),
      .last_i    (s == NR_MAX),
      .valid_o   (vld[s]),
      .state_o   (st[s])
    );
  end

  assign out_valid_o         = vld[NR_MAX];
  assign out_data_o.plain_hi = st[NR_MAX][127:64];
  assign out_data_o.plain_lo = st[NR_MAX][63:0];

endmodule

// ===== src/aesd_key_expand.sv =====
// key expansion unit: one schedule word per cycle into the round key registers
// depends on aesd_pkg
module aesd_key_expand import aesd_pkg::*; (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          restart_i,
  input  key_len_e                      key_len_i,
  input  logic [3:0][63:0]              key_bits_i,
  output logic                          ready_o,
  output logic [NR_MAX:0][127:0]        round_keys_o,
  output logic [127:0]                  first_key_o
);

  logic [31:0]           rk_q [RK_WORDS];
  logic [127:0]          first_q;
  logic [7:0][31:0]      win_q, win_d;
  logic [RK_IDX_W-1:0]   idx_q, idx_d;
  logic [2:0]            mod_q, mod_d;
  logic [7:0]            rcon_q, rcon_d;
  logic                  ready_q, ready_d;
  logic [3:0]            nk;
  logic [RND_W-1:0]      nr;
  logic [RK_IDX_W-1:0]   last_idx;
  logic [63:0]           kb;
  logic [31:0]           t;
  logic [31:0]           w;

  // key size decode, code three saturates to the long key
  always_comb begin
    unique case (key_len_i)
      KEY_128: nk = 4'd4;
      KEY_192: nk = 4'd6;
      default: nk = 4'd8;
    endcase
  end

  assign nr       = RND_W'(nk + 4'd6);
  assign last_idx = RK_IDX_W'({nr, 2'b11});

  // next schedule word
  always_comb begin
    kb     = key_bits_i[idx_q[2:1]];
    t      = win_q[0];
    rcon_d = rcon_q;
    if (RK_IDX_W'(nk) > idx_q) begin
      w = idx_q[0] ? kb[31:0] : kb[63:32];
    end else begin
      if (mod_q == 3'd0) begin
        t      = sub_word({t[23:0], t[31:24]}) ^ {rcon_q, 24'h0};
        rcon_d = xtime(rcon_q);
      end else if (nk == 4'd8 && mod_q == 3'd4) begin
        t = sub_word(t);
      end
      w = win_q[3'(nk - 4'd1)] ^ t;
    end
    win_d   = {win_q[6:0], w};
    mod_d   = (4'(mod_q) == nk - 4'd1) ? 3'd0 : mod_q + 3'd1;
    idx_d   = idx_q + RK_IDX_W'(1);
    ready_d = (idx_q == last_idx);
  end

  // sequencer control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ready_q <= 1'b0;
      idx_q   <= '0;
      mod_q   <= 3'd0;
      rcon_q  <= 8'h01;
    end else if (restart_i) begin
      ready_q <= 1'b0;
      idx_q   <= '0;
      mod_q   <= 3'd0;
      rcon_q  <= 8'h01;
    end else if (!ready_q) begin
      ready_q <= ready_d;
      idx_q   <= idx_d;
      mod_q   <= mod_d;
      rcon_q  <= rcon_d;
    end
  end

  // round key store and window
  always_ff @(posedge clk_i) begin
    if (!ready_q && !restart_i) begin
      win_q      <= win_d;
      rk_q[idx_q] <= w;
      if (idx_q[RK_IDX_W-1:2] == nr) begin
        first_q[127-32*idx_q[1:0] -: 32] <= w;
      end
    end
  end

  always_comb begin
    for (int r = 0; r <= NR_MAX; r++) begin
      round_keys_o[r] = {rk_q[4*r], rk_q[4*r+1], rk_q[4*r+2], rk_q[4*r+3]};
    end
  end

  assign ready_o     = ready_q;
  assign first_key_o = first_q;

endmodule

// ===== src/aesd_round.sv =====
// inverse round stage: shift rows, inv s-box, key add, inv mix unless last
// depends on aesd_pkg; passes the state unchanged when inactive
module aesd_round import aesd_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         advance_i,
  input  logic         valid_i,
  input  logic [127:0] state_i,
  input  logic [127:0] key_i,
  input  logic         active_i,
  input  logic         last_i,
  output logic         valid_o,
  output logic [127:0] state_o
);

  logic         valid_q;
  logic [127:0] state_q, state_d;
  logic [127:0] ss;
  logic [127:0] ak;

  // byte n of the state sits at bits 127-8n
  always_comb begin
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        ss[127-8*(4*c+r) -: 8] = ISBOX[state_i[127-8*(4*((c-r)&3)+r) -: 8]];
      end
    end
    ak = ss ^ key_i;
    for (int c = 0; c < 4; c++) begin
      state_d[127-32*c -: 32] = last_i ? ak[127-32*c -: 32]
                                       : inv_mix_col(ak[127-32*c -: 32]);
    end
    if (!active_i) state_d = state_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (advance_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_i) state_q <= state_d;
  end

  assign valid_o = valid_q;
  assign state_o = state_q;

endmodule

// ===== tb/aes_block_decrypt_tb.sv =====
// self-checking bench for the aes block decrypt: directed rows, some with known answers, then random keys and blocks
// depends on aesd_pkg and aes_block_decrypt; predicts each plaintext without a known answer with its own inverse cipher
module aes_block_decrypt_tb;
  import aesd_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] CFG_FIRST_SPARE = 3'd5;
  localparam logic [2:0] CFG_LAST_SPARE  = 3'd7;
  localparam int unsigned DRAIN_CYCLES   = 24;
  localparam int unsigned HOLD_CYCLES    = 300;
  localparam int unsigned RANDOM_BLOCKS  = 1040;
  localparam int unsigned REPORT_LIMIT   = 10;
  localparam int unsigned DIR_ROWS       = 12;

  localparam logic [255:0] KEY_FIPS_128 = {128'h000102030405060708090a0b0c0d0e0f, 128'h0};
  localparam logic [255:0] KEY_FIPS_192 = {192'h000102030405060708090a0b0c0d0e0f1011121314151617,
                                           64'h0};
  localparam logic [255:0] KEY_FIPS_256 =
    256'h000102030405060708090a0b0c0d0e0f101112131415161718191a1b1c1d1e1f;
  localparam logic [127:0] PLAIN_FIPS   = 128'h00112233445566778899aabbccddeeff;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  in_data_t    in_data_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  out_data_t   out_data_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i = '0;
  logic [63:0] cfg_data_i = '0;

  aes_block_decrypt dut (.*);

  always #2 clk_i = ~clk_i;

  // predictor state: configuration, schedule and byte tables
  logic [1:0]  pred_key_len;
  logic [63:0] pred_key [4];
  logic [31:0] pred_sched [60];
  bit          pred_sched_ok;
  logic [7:0]  fwd_sub [256];
  logic [7:0]  rev_sub [256];

  out_data_t   plain_queue [$];
  int unsigned fail_count = 0;
  bit          no_idle = 0;
  bit          hold_req = 0;

  typedef struct packed {
    bit           do_cfg;
    logic [1:0]   key_len;
    logic [255:0] key_bits;
    logic [127:0] cipher;
    bit           known;
    logic [127:0] plain;
  } dir_row_t;

  dir_row_t dir_rows [DIR_ROWS];

  function automatic logic [7:0] gf_dbl(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] gf_prod(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] acc;
    acc = 8'h00;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) acc ^= a;
      a = gf_dbl(a);
    end
    return acc;
  endfunction

  // forward s-box: inverse as a to the 254, then the affine map
  function automatic logic [7:0] sub_byte_of(input logic [7:0] x);
    logic [7:0] inv;
    inv = 8'h01;
    for (int i = 0; i < 254; i++) inv = gf_prod(inv, x);
    return inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]} ^ {inv[4:0], inv[7:5]}
         ^ {inv[3:0], inv[7:4]} ^ 8'h63;
  endfunction

  function automatic logic [31:0] sub_word_of(input logic [31:0] w);
    return {fwd_sub[w[31:24]], fwd_sub[w[23:16]], fwd_sub[w[15:8]], fwd_sub[w[7:0]]};
  endfunction

  function automatic int unsigned key_words_of(input logic [1:0] kl);
    case (kl)
      KEY_128: return 4;
      KEY_192: return 6;
      default: return 8;
    endcase
  endfunction

  // key schedule, rebuilt on the first block after any config change
  function automatic void build_schedule();
    int unsigned nk;
    int unsigned total;
    logic [31:0] t;
    logic [7:0]  rcon;
    nk = key_words_of(pred_key_len);
    total = 4 * (nk + 7);
    rcon = 8'h01;
    for (int i = 0; i < 60; i++) pred_sched[i] = '0;
    for (int i = 0; i < nk; i++)
      pred_sched[i] = (i % 2) ? pred_key[i / 2][31:0] : pred_key[i / 2][63:32];
    for (int i = nk; i < total; i++) begin
      t = pred_sched[i - 1];
      if (i % nk == 0) begin
        t = sub_word_of({t[23:0], t[31:24]}) ^ {rcon, 24'h0};
        rcon = gf_dbl(rcon);
      end else if (nk > 6 && i % nk == 4) begin
        t = sub_word_of(t);
      end
      pred_sched[i] = pred_sched[i - nk] ^ t;
    end
    pred_sched_ok = 1;
  endfunction

  function automatic void mix_key(ref logic [7:0] s [16], input int unsigned rnd);
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++)
        s[4*c+r] ^= pred_sched[rnd*4+c][31-8*r -: 8];
  endfunction

  function automatic void unshift_unsub(ref logic [7:0] s [16]);
    logic [7:0] t [16];
    t = s;
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++)
        s[4*c+r] = rev_sub[t[4*((c - r) & 3)+r]];
  endfunction

  function automatic out_data_t plain_of(input in_data_t blk);
    logic [7:0]  s [16];
    logic [7:0]  a [4];
    logic [127:0] flat;
    int unsigned nr;
    if (!pred_sched_ok) build_schedule();
    nr = key_words_of(pred_key_len) + 6;
    flat = blk;
    for (int i = 0; i < 16; i++) s[i] = flat[127-8*i -: 8];
    mix_key(s, nr);
    for (int rnd = nr - 1; rnd >= 1; rnd--) begin
      unshift_unsub(s);
      mix_key(s, rnd);
      // inverse column mix
      for (int c = 0; c < 4; c++) begin
        for (int r = 0; r < 4; r++) a[r] = s[4*c+r];
        for (int r = 0; r < 4; r++)
          s[4*c+r] = gf_prod(a[r], 8'h0e) ^ gf_prod(a[(r+1)%4], 8'h0b)
                   ^ gf_prod(a[(r+2)%4], 8'h0d) ^ gf_prod(a[(r+3)%4], 8'h09);
      end
    end
    unshift_unsub(s);
    mix_key(s, 0);
    for (int i = 0; i < 16; i++) flat[127-8*i -: 8] = s[i];
    return out_data_t'(flat);
  endfunction

  // one config register write over its own channel
  task automatic write_reg(input logic [2:0] idx, input logic [63:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == CFG_KEY_LENGTH) begin
      pred_key_len = data[1:0];
      pred_sched_ok = 0;
    end else if (idx >= CFG_KEY_BITS_0 && idx <= CFG_KEY_BITS_3) begin
      pred_key[idx - CFG_KEY_BITS_0] = data;
      pred_sched_ok = 0;
    end
  endtask

  // wait for every pending result, then let the pipeline settle
  task automatic drain();
    in_valid_i <= 1'b0;
    while (plain_queue.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // full reprogram; upper bits of key_length are junk, plus a write to a spare index
  task automatic load_key(input logic [1:0] kl, input logic [255:0] kb);
    drain();
    write_reg(CFG_KEY_BITS_0, kb[255:192]);
    write_reg(CFG_KEY_BITS_1, kb[191:128]);
    write_reg(CFG_KEY_BITS_2, kb[127:64]);
    write_reg(CFG_KEY_BITS_3, kb[63:0]);
    write_reg(CFG_KEY_LENGTH, {$urandom(), 30'($urandom()), kl});
    write_reg(3'($urandom_range(CFG_FIRST_SPARE, CFG_LAST_SPARE)), {$urandom(), $urandom()});
  endtask

  // offer one request; expectation is queued when it is accepted
  task automatic send_block(input in_data_t blk, input bit known, input out_data_t plain);
    int unsigned gap;
    out_data_t   pred;
    gap = no_idle ? 0 : $urandom_range(0, 3);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= blk;
    do @(posedge clk_i); while (in_stall_o);
    pred = plain_of(blk);
    plain_queue.push_back(known ? plain : pred);
  endtask

  // result side stall pattern, with one long hold in the second random phase
  initial begin
    int unsigned gap;
    forever begin
      if (hold_req) begin
        hold_req = 0;
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end
      gap = no_idle ? 0 : $urandom_range(0, 3);
      if (gap != 0) begin
        out_stall_i <= 1'b1;
        repeat (gap) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!(rst_ni && out_valid_o));
    end
  end

  // compare each accepted result with the oldest expectation
  always @(posedge clk_i) begin
    out_data_t exp_plain;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (plain_queue.size() == 0) begin
        fail_count++;
        if (fail_count <= REPORT_LIMIT)
          $display("unexpected result %h %h", out_data_o.plain_hi, out_data_o.plain_lo);
      end else begin
        exp_plain = plain_queue.pop_front();
        if (out_data_o.plain_hi !== exp_plain.plain_hi ||
            out_data_o.plain_lo !== exp_plain.plain_lo) begin
          fail_count++;
          if (fail_count <= REPORT_LIMIT)
            $display("plaintext mismatch: expected %h %h actual %h %h",
                     exp_plain.plain_hi, exp_plain.plain_lo,
                     out_data_o.plain_hi, out_data_o.plain_lo);
        end
      end
    end
  end

  // run limit
  initial begin
    #2ms;
    $display("Verification failed");
    $finish;
  end

  // stimulus
  initial begin
    int unsigned sent;
    int unsigned n;
    int unsigned phase;
    logic [255:0] kb;
    for (int x = 0; x < 256; x++) fwd_sub[x] = sub_byte_of(8'(x));
    for (int x = 0; x < 256; x++) rev_sub[fwd_sub[x]] = 8'(x);
    pred_key_len = KEY_128;
    for (int i = 0; i < 4; i++) pred_key[i] = '0;
    pred_sched_ok = 0;

    // do_cfg, key length, key bits, ciphertext, known answer flag, plaintext
    dir_rows = '{
      '{1'b0, KEY_128, 256'h0, 128'h0, 1'b0, 128'h0},
      '{1'b0, KEY_128, 256'h0, {128{1'b1}}, 1'b0, 128'h0},
      '{1'b1, KEY_128, KEY_FIPS_128, 128'h69c4e0d86a7b0430d8cdb78070b4c55a, 1'b1, PLAIN_FIPS},
      '{1'b0, KEY_128, KEY_FIPS_128, 128'h0, 1'b0, 128'h0},
      '{1'b1, KEY_192, KEY_FIPS_192, 128'hdda97ca4864cdfe06eaf70a0ec0d7191, 1'b1, PLAIN_FIPS},
      '{1'b1, KEY_256, KEY_FIPS_256, 128'h8ea2b7ca516745bfeafc49904b496089, 1'b1, PLAIN_FIPS},
      '{1'b0, KEY_256, KEY_FIPS_256, {128{1'b1}}, 1'b0, 128'h0},
      // key length code three acts as a 256-bit key
      '{1'b1, KEY_SAT, KEY_FIPS_256, 128'h8ea2b7ca516745bfeafc49904b496089, 1'b1, PLAIN_FIPS},
      // bytes beyond the key length are ignored
      '{1'b1, KEY_128, {128'h000102030405060708090a0b0c0d0e0f, {128{1'b1}}},
        128'h69c4e0d86a7b0430d8cdb78070b4c55a, 1'b1, PLAIN_FIPS},
      '{1'b1, KEY_128, {256{1'b1}}, {128{1'b1}}, 1'b0, 128'h0},
      '{1'b1, KEY_256, {256{1'b1}}, 128'h0, 1'b0, 128'h0},
      '{1'b1, KEY_192, {192'h0, {64{1'b1}}}, {64'h0, {64{1'b1}}}, 1'b0, 128'h0}
    };

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed rows
    foreach (dir_rows[i]) begin
      if (dir_rows[i].do_cfg) load_key(dir_rows[i].key_len, dir_rows[i].key_bits);
      send_block(in_data_t'(dir_rows[i].cipher), dir_rows[i].known,
                 out_data_t'(dir_rows[i].plain));
    end

    // random phases, each with a fresh key
    sent = 0;
    phase = 0;
    while (sent < RANDOM_BLOCKS) begin
      kb = {$urandom(), $urandom(), $urandom(), $urandom(),
            $urandom(), $urandom(), $urandom(), $urandom()};
      if ($urandom_range(0, 7) == 0) kb = $urandom_range(0, 1) ? '1 : '0;
      load_key(2'($urandom_range(0, 3)), kb);
      no_idle = ($urandom_range(0, 3) == 0);
      if (phase == 1) begin
        no_idle = 1;
        hold_req = 1;
      end
      n = $urandom_range(60, 110);
      for (int i = 0; i < n; i++)
        send_block({$urandom(), $urandom(), $urandom(), $urandom()}, 1'b0, '0);
      sent += n;
      phase++;
    end

    no_idle = 0;
    drain();
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/aesd_pkg.sv
src/aesd_key_expand.sv
src/aesd_round.sv
src/aes_block_decrypt.sv
tb/aes_block_decrypt_tb.sv
